// File: rtl/pvs_pkg.sv
// Shared types, widths and helper functions for the polynomial value and slope core.
// Depends on nothing; every other file of the core uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pvs_pkg;

   localparam int DATA_W    = 32;
   localparam int DEG_W     = 3;
   localparam int NUM_COEFS = 7;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int TERM_W    = DATA_W + 4;
   localparam int INDEX_W   = 3;

   localparam logic [INDEX_W-1:0] REG_DEGREE    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_COEF_BASE = 3'd1;

   typedef logic [NUM_COEFS-1:0][DATA_W-1:0] coef_array_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] slp;
      logic [DEG_W-1:0]         deg;
      logic                     clip;
   } stage_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     clip;
   } sat_type;

   function automatic sat_type saturate(input logic signed [SUM_W-1:0] v);
      sat_type r;
      logic [SUM_W-DATA_W:0] top;
      top = v[SUM_W-1:DATA_W-1];
      if ((top == '0) || (top == '1)) begin
         r.val  = v[DATA_W-1:0];
         r.clip = 1'b0;
      end else begin
         r.val  = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         r.clip = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pvs_req_if.sv
// Input channel of the polynomial value and slope core: valid, ready and the point.
// Depends on pvs_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface pvs_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pvs_pkg::DATA_W-1:0] point;

   modport source (output valid, output point, input ready);
   modport sink (input valid, input point, output ready);
endinterface

`default_nettype wire

// File: rtl/pvs_rsp_if.sv
// Result channel of the polynomial value and slope core: valid, ready, value, slope, flag.
// Depends on pvs_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface pvs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pvs_pkg::DATA_W-1:0] value;
   logic signed [pvs_pkg::DATA_W-1:0] slope;
   logic                              saturated;

   modport source (output valid, output value, output slope, output saturated, input ready);
   modport sink (input valid, input value, input slope, input saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/pvs_load.sv
// First pipeline stage: clamps the degree and loads the leading Horner terms.
// Depends on pvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvs_load #(
   parameter int MAX_DEGREE = 6
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    in_valid,
   output logic                                   in_ready,
   input  wire logic signed [pvs_pkg::DATA_W-1:0] in_point,
   input  wire logic [pvs_pkg::DEG_W-1:0]         degree,
   input  wire pvs_pkg::coef_array_type           coefs,
   output logic                                   out_valid,
   input  wire                                    out_ready,
   output pvs_pkg::stage_type                     out_stage
);

   localparam logic [pvs_pkg::DEG_W-1:0] MAX_D = pvs_pkg::DEG_W'(MAX_DEGREE);

   logic                                   valid_ff, valid_in;
   pvs_pkg::stage_type                     stage_ff, stage_in;
   logic [pvs_pkg::DEG_W-1:0]              deg_use;
   logic signed [pvs_pkg::DATA_W-1:0]      lead;
   logic signed [pvs_pkg::TERM_W-1:0]      lead_term;
   logic signed [pvs_pkg::SUM_W-1:0]       lead_ext;
   pvs_pkg::sat_type                       lead_sat;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      deg_use   = (degree > MAX_D) ? MAX_D : degree;
      lead      = $signed(coefs[deg_use]);
      lead_term = $signed({{(pvs_pkg::TERM_W-pvs_pkg::DATA_W){lead[pvs_pkg::DATA_W-1]}}, lead})
                * $signed({{(pvs_pkg::TERM_W-pvs_pkg::DEG_W){1'b0}}, deg_use});
      lead_ext  = {{(pvs_pkg::SUM_W-pvs_pkg::TERM_W){lead_term[pvs_pkg::TERM_W-1]}}, lead_term};
      lead_sat  = pvs_pkg::saturate(lead_ext);

      valid_in = valid_ff;
      stage_in = stage_ff;
      if (in_ready) begin
         valid_in       = in_valid;
         stage_in.x     = in_point;
         stage_in.val   = lead;
         stage_in.slp   = lead_sat.val;
         stage_in.deg   = deg_use;
         stage_in.clip  = lead_sat.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// File: rtl/pvs_step.sv
// One Horner step for value and slope: a multiply stage followed by a
// shift, add and saturate stage. Depends on pvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvs_step #(
   parameter int IDX       = 0,
   parameter int FRAC_BITS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    in_valid,
   output logic                                   in_ready,
   input  wire pvs_pkg::stage_type                in_stage,
   input  wire logic signed [pvs_pkg::DATA_W-1:0] coef,
   output logic                                   out_valid,
   input  wire                                    out_ready,
   output pvs_pkg::stage_type                     out_stage
);

   localparam logic [pvs_pkg::DEG_W-1:0] IDX_D    = pvs_pkg::DEG_W'(IDX);
   localparam bit                        SLP_STEP = (IDX >= 1);

   logic                               m_valid_ff, m_valid_in;
   pvs_pkg::stage_type                 m_stage_ff, m_stage_in;
   logic signed [pvs_pkg::PROD_W-1:0]  m_vprod_ff, m_vprod_in;
   logic signed [pvs_pkg::PROD_W-1:0]  m_sprod_ff, m_sprod_in;
   logic                               m_ready;

   logic                               a_valid_ff, a_valid_in;
   pvs_pkg::stage_type                 a_stage_ff, a_stage_in;

   logic signed [pvs_pkg::PROD_W-1:0]  v_shift;
   logic signed [pvs_pkg::PROD_W-1:0]  s_shift;
   logic signed [pvs_pkg::TERM_W-1:0]  s_term;
   logic signed [pvs_pkg::SUM_W-1:0]   v_sum;
   logic signed [pvs_pkg::SUM_W-1:0]   s_sum;
   pvs_pkg::sat_type                   v_sat;
   pvs_pkg::sat_type                   s_sat;
   logic                               v_active;
   logic                               s_active;

   assign m_ready  = !a_valid_ff || out_ready;
   assign in_ready = !m_valid_ff || m_ready;

   always_comb begin
      m_valid_in = m_valid_ff;
      m_stage_in = m_stage_ff;
      m_vprod_in = m_vprod_ff;
      m_sprod_in = m_sprod_ff;
      if (in_ready) begin
         m_valid_in = in_valid;
         m_stage_in = in_stage;
         m_vprod_in = pvs_pkg::PROD_W'(in_stage.val) * pvs_pkg::PROD_W'(in_stage.x);
         m_sprod_in = pvs_pkg::PROD_W'(in_stage.slp) * pvs_pkg::PROD_W'(in_stage.x);
      end
   end

   always_comb begin
      v_shift  = m_vprod_ff >>> FRAC_BITS;
      s_shift  = m_sprod_ff >>> FRAC_BITS;
      s_term   = $signed({{(pvs_pkg::TERM_W-pvs_pkg::DATA_W){coef[pvs_pkg::DATA_W-1]}}, coef})
               * $signed({{(pvs_pkg::TERM_W-pvs_pkg::DEG_W){1'b0}}, IDX_D});
      v_sum    = $signed({v_shift[pvs_pkg::PROD_W-1], v_shift})
               + $signed({{(pvs_pkg::SUM_W-pvs_pkg::DATA_W){coef[pvs_pkg::DATA_W-1]}}, coef});
      s_sum    = $signed({s_shift[pvs_pkg::PROD_W-1], s_shift})
               + $signed({{(pvs_pkg::SUM_W-pvs_pkg::TERM_W){s_term[pvs_pkg::TERM_W-1]}}, s_term});
      v_sat    = pvs_pkg::saturate(v_sum);
      s_sat    = pvs_pkg::saturate(s_sum);
      v_active = IDX_D < m_stage_ff.deg;
      s_active = SLP_STEP && v_active;

      a_valid_in = a_valid_ff;
      a_stage_in = a_stage_ff;
      if (m_ready) begin
         a_valid_in = m_valid_ff;
         a_stage_in = m_stage_ff;
         if (v_active) begin
            a_stage_in.val  = v_sat.val;
            a_stage_in.clip = a_stage_in.clip | v_sat.clip;
         end
         if (s_active) begin
            a_stage_in.slp  = s_sat.val;
            a_stage_in.clip = a_stage_in.clip | s_sat.clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         a_valid_ff <= a_valid_in;
      end
      m_stage_ff <= m_stage_in;
      m_vprod_ff <= m_vprod_in;
      m_sprod_ff <= m_sprod_in;
      a_stage_ff <= a_stage_in;
   end

   assign out_valid = a_valid_ff;
   assign out_stage = a_stage_ff;

   a_clip_sticky: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && m_ready && m_stage_ff.clip |=> a_stage_ff.clip)
      else $error("Saturation flag was lost in a Horner step.");

   a_idle_passes: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && m_ready && (m_stage_ff.deg <= IDX_D)
      |=> a_stage_ff.val == $past(m_stage_ff.val) && a_stage_ff.slp == $past(m_stage_ff.slp))
      else $error("An unused Horner step changed the accumulators.");

   a_x_carried: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && m_ready |=> a_valid_ff && a_stage_ff.x == $past(m_stage_ff.x))
      else $error("Evaluation point was not carried through the step.");

endmodule

`default_nettype wire

// File: rtl/polynomial_value_and_slope_core.sv
// Top level of the polynomial value and slope core: configuration registers and
// the Horner pipeline. Depends on pvs_pkg, pvs_req_if, pvs_rsp_if, pvs_load and pvs_step.
`timescale 1ns / 1ps
`default_nettype none

// The core evaluates p(x) and p'(x) by Horner's rule in signed fixed point and
// accepts one point per clock cycle while no stall holds the input. Each point
// passes one load stage, then for every Horner step a stage with a pair of 32 by
// 32 multipliers and a stage that shifts, adds and saturates. All steps are
// always traversed; steps at or above the configured degree pass the
// accumulators through. Each stage holds its item on a stall, so the input keeps
// taking transfers until the pipeline is full. The degree and coefficient
// registers are to be written only while no point is in flight.

module polynomial_value_and_slope_core #(
   parameter int MAX_DEGREE = 6,
   parameter int FRAC_BITS  = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   pvs_req_if.sink                             req_if,
   pvs_rsp_if.source                           rsp_if,
   input  wire                                 csr_write_en,
   input  wire logic [pvs_pkg::INDEX_W-1:0]    csr_index,
   input  wire logic [pvs_pkg::DATA_W-1:0]     csr_wdata
);

   logic [pvs_pkg::DEG_W-1:0]   degree_ff, degree_in;
   pvs_pkg::coef_array_type     coef_ff, coef_in;

   logic                        valid [MAX_DEGREE+1];
   logic                        ready [MAX_DEGREE+1];
   pvs_pkg::stage_type          stage [MAX_DEGREE+1];

   always_comb begin
      degree_in = degree_ff;
      coef_in   = coef_ff;
      if (csr_write_en) begin
         if (csr_index == pvs_pkg::REG_DEGREE) begin
            degree_in = csr_wdata[pvs_pkg::DEG_W-1:0];
         end else begin
            coef_in[pvs_pkg::INDEX_W'(csr_index - pvs_pkg::REG_COEF_BASE)] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         coef_ff   <= '0;
      end else begin
         degree_ff <= degree_in;
         coef_ff   <= coef_in;
      end
   end

   pvs_load #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_load (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_point  (req_if.point),
      .degree    (degree_ff),
      .coefs     (coef_ff),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_stage (stage[0])
   );

   for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
      pvs_step #(
         .IDX       (MAX_DEGREE - 1 - k),
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[k]),
         .in_ready  (ready[k]),
         .in_stage  (stage[k]),
         .coef      ($signed(coef_ff[MAX_DEGREE - 1 - k])),
         .out_valid (valid[k+1]),
         .out_ready (ready[k+1]),
         .out_stage (stage[k+1])
      );
   end

   assign ready[MAX_DEGREE]  = rsp_if.ready;
   assign rsp_if.valid       = valid[MAX_DEGREE];
   assign rsp_if.value       = stage[MAX_DEGREE].val;
   assign rsp_if.slope       = stage[MAX_DEGREE].slp;
   assign rsp_if.saturated   = stage[MAX_DEGREE].clip;

   a_no_result_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_if.valid)
      else $error("Result transfer offered right after reset.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> valid[0])
      else $error("Input refused while the load stage is empty.");

   a_constant_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (stage[MAX_DEGREE].deg == '0) |-> rsp_if.slope == '0 && !rsp_if.saturated)
      else $error("Constant polynomial gave a nonzero slope or a saturation.");

   a_degree_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> stage[MAX_DEGREE].deg <= pvs_pkg::DEG_W'(MAX_DEGREE))
      else $error("Degree above the limit reached the output.");

endmodule

`default_nettype wire

// File: tb/sv/polynomial_value_and_slope_core_tb.sv
// Self-checking testbench for polynomial_value_and_slope_core: directed and random points
// under many degree and coefficient settings, with random idling on both channels.
// Depends on pvs_pkg, pvs_req_if, pvs_rsp_if and the core itself.
`timescale 1ns / 1ps

module polynomial_value_and_slope_core_tb;

   localparam int MAX_DEGREE  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_COEFS   = pvs_pkg::NUM_COEFS;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 85;

   typedef logic [pvs_pkg::DATA_W-1:0] word_type;

   typedef struct {
      logic signed [31:0] value;
      logic signed [31:0] slope;
      logic               saturated;
   } horner_out_type;

   // Golden Horner evaluator plus the queue of results still owed by the core.
   class horner_ledger_type;
      logic [2:0]         degree;
      logic signed [31:0] coefs[NUM_COEFS];
      horner_out_type     awaited_evals[$];
      int                 errors;
      int                 checked;
      int                 clipped;

      function new();
         degree = '0;
         foreach (coefs[i]) coefs[i] = '0;
         errors = 0;
         checked = 0;
         clipped = 0;
      endfunction

      function void set_register(logic [2:0] idx, word_type data);
         if (idx == pvs_pkg::REG_DEGREE) begin
            degree = data[2:0];
         end else begin
            coefs[idx - pvs_pkg::REG_COEF_BASE] = data;
         end
      endfunction

      function longint clamp32(longint v, inout bit clip);
         if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function void note_point(logic signed [31:0] pt);
         horner_out_type e;
         longint         x;
         longint         acc;
         longint         grad;
         int             d;
         int             i;
         bit             clip;
         x = longint'(pt);
         d = (degree > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
         clip = 1'b0;
         acc = longint'(coefs[d]);
         for (i = d - 1; i >= 0; i--) begin
            acc = clamp32(((acc * x) >>> FRAC_BITS) + longint'(coefs[i]), clip);
         end
         if (d == 0) begin
            grad = 0;
         end else begin
            grad = clamp32(longint'(d) * longint'(coefs[d]), clip);
            for (i = d - 1; i >= 1; i--) begin
               grad = clamp32(((grad * x) >>> FRAC_BITS) + longint'(i) * longint'(coefs[i]),
                              clip);
            end
         end
         e.value = acc[31:0];
         e.slope = grad[31:0];
         e.saturated = clip;
         awaited_evals.push_back(e);
      endfunction

      function void check_result(logic signed [31:0] v, logic signed [31:0] s, logic f);
         horner_out_type e;
         if (awaited_evals.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: unexpected result value=%h slope=%h saturated=%b",
                        $time, v, s, f);
            end
            return;
         end
         e = awaited_evals.pop_front();
         checked++;
         if (f === 1'b1) clipped++;
         if (e.value !== v || e.slope !== s || e.saturated !== f) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result %0d mismatch: expected value=%h slope=%h saturated=%b,",
                        $time, checked, e.value, e.slope, e.saturated);
               $display("   got value=%h slope=%h saturated=%b", v, s, f);
            end
         end
      endfunction

      function int pending();
         return awaited_evals.size();
      endfunction

      function int failures();
         return errors + awaited_evals.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_en;
   logic [2:0] csr_index;
   word_type   csr_wdata;

   pvs_req_if req_bus ();
   pvs_rsp_if rsp_bus ();

   horner_ledger_type ledger;
   bit                req_eager;
   bit                rsp_eager;
   int                setting_count;
   word_type          batch[$];
   word_type          coef_set[NUM_COEFS];

   polynomial_value_and_slope_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_bus),
      .rsp_if       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic word_type random_q(int unsigned min_w, int unsigned max_w);
      word_type    raw;
      int unsigned w;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return raw;
         default: begin
            w = $urandom_range(min_w, max_w);
            return word_type'($signed(raw << (32 - w)) >>> (32 - w));
         end
      endcase
   endfunction

   task automatic pick_idling();
      logic [1:0] mode;
      mode = 2'($urandom_range(0, 3));
      req_eager = mode[0];
      rsp_eager = mode[1];
   endtask

   task automatic apply_settings(input logic [2:0] deg, input word_type coefs[NUM_COEFS]);
      int i;
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = pvs_pkg::REG_DEGREE;
      csr_wdata = {29'd0, deg};
      ledger.set_register(pvs_pkg::REG_DEGREE, {29'd0, deg});
      for (i = 0; i < NUM_COEFS; i++) begin
         @(negedge clock);
         csr_index = pvs_pkg::REG_COEF_BASE + 3'(i);
         csr_wdata = coefs[i];
         ledger.set_register(pvs_pkg::REG_COEF_BASE + 3'(i), coefs[i]);
      end
      @(negedge clock);
      csr_write_en = 1'b0;
      setting_count++;
   endtask

   task automatic send_point(input word_type pt);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.point = pt;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_point(pt);
   endtask

   task automatic send_batch();
      foreach (batch[i]) send_point(batch[i]);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic drain();
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: random ready stalls, every transfer is checked at the rising edge.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         gap = rsp_eager ? 0 : $urandom_range(0, 14);
         @(negedge clock);
         if (gap != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         ledger.check_result(rsp_bus.value, rsp_bus.slope, rsp_bus.saturated);
      end
   end

   initial begin
      int p;
      int n;
      int i;
      ledger = new();
      setting_count = 0;
      req_eager = 1'b0;
      rsp_eager = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.point = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All registers still at their reset value.
      pick_idling();
      batch = {32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      send_batch();
      drain();

      // Degree zero returns the constant term; higher coefficients must be ignored.
      coef_set = '{32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      apply_settings(3'd0, coef_set);
      pick_idling();
      batch = {32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000};
      send_batch();
      drain();

      // A degree of seven is limited to six.
      foreach (coef_set[k]) coef_set[k] = 32'h0001_0000;
      apply_settings(3'd7, coef_set);
      pick_idling();
      batch = {32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_8000};
      send_batch();
      drain();

      // Full-scale coefficients and points drive both recurrences into saturation.
      coef_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      apply_settings(3'd6, coef_set);
      pick_idling();
      batch = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 32'hFFFF_FFFF};
      send_batch();
      drain();

      coef_set = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      apply_settings(3'd2, coef_set);
      pick_idling();
      batch = {32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678};
      send_batch();
      drain();

      coef_set = '{word_type'($urandom), 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      apply_settings(3'd1, coef_set);
      pick_idling();
      batch = {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      send_batch();
      drain();

      for (p = 0; p < RAND_PHASES; p++) begin
         foreach (coef_set[k]) coef_set[k] = random_q(6, 24);
         apply_settings(3'($urandom_range(0, 7)), coef_set);
         pick_idling();
         n = PHASE_ITEMS;
         batch = {};
         for (i = 0; i < n; i++) batch.push_back(random_q(8, 19));
         send_batch();
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Evaluated %0d points under %0d register settings, %0d of them saturated.",
               ledger.checked, setting_count, ledger.clipped);
      $display("Mismatching or missing results: %0d", ledger.failures());
      if (ledger.failures() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
